>>> sv/assert_macros.svh
// Assertion macros shared by the contact slot tracker RTL.
// Included by the modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, ignored while reset is held
`define TCST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define TCST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tcst_pkg.sv
// Package for the touch contact slot tracker: widths, codes and the structs
// passed between the slot cells and the top level. No dependencies.
package tcst_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int IDX_W         = 5;
  localparam int SLOT_W        = 4;
  localparam int ID_W          = 32;
  localparam int PIX_W         = 16;
  localparam int PTS_W         = 24;
  localparam int SCALE_W       = 24;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_END    = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_KNOWN   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X    = 2'd0,
    CFG_ORIGIN_Y    = 2'd1,
    CFG_INV_SCALE_X = 2'd2,
    CFG_INV_SCALE_Y = 2'd3
  } cfg_idx_t;

  // lookup token walking along the slot chain
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } tok_t;

  // slot update broadcast at commit
  typedef struct packed {
    logic             we;
    logic             set_used;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  id;
  } upd_t;

endpackage

>>> sv/tcst_cell.sv
// One contact slot: used bit, owner id and one stage of the lookup chain.
// Depends on tcst_pkg.
module tcst_cell import tcst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [ID_W-1:0]  id,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  upd_t             upd,
  output logic             used_o
);

  logic            used_r;
  logic            used_nxt;
  logic [ID_W-1:0] owner_r;
  tok_t            tok_r;
  tok_t            tok_nxt;
  logic            hit;

  assign hit = upd.we && (upd.idx == cell_idx);

  always_comb begin
    used_nxt = used_r;
    if (hit) begin
      used_nxt = upd.set_used;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.found && used_r && (owner_r == id)) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.found_idx = cell_idx;
    end
    if (!tok_in.free_found && !used_r) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && upd.set_used) begin
      owner_r <= upd.id;
    end
  end

  assign tok_out = tok_r;
  assign used_o  = used_r;

endmodule

>>> sv/tcst_scale.sv
// Position scaling: (pixel - origin) * reciprocal scale, rounded to Q16.8 and
// saturated. One registered multiply, then round and clamp. Depends on tcst_pkg.
module tcst_scale import tcst_pkg::*; (
  input  logic                    clk,
  input  logic [PIX_W-1:0]        pixel,
  input  logic signed [PIX_W-1:0] origin,
  input  logic [SCALE_W-1:0]      inv_scale,
  output logic signed [PTS_W-1:0] points
);

  localparam int D_W = PIX_W + 2;
  localparam int P_W = D_W + SCALE_W + 1;
  localparam int Q_W = P_W - 8;

  logic signed [D_W-1:0] diff;
  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] prod_r;
  logic signed [P_W-1:0] rnd;
  logic signed [Q_W-1:0] quo;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (PTS_W - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(64'sd1 <<< (PTS_W - 1)));

  assign diff = $signed({2'b00, pixel}) - $signed({{2{origin[PIX_W-1]}}, origin});
  assign prod = diff * $signed({1'b0, inv_scale});

  always_ff @(posedge clk) begin
    prod_r <= prod;
  end

  assign rnd = prod_r + P_W'(128);
  assign quo = rnd[P_W-1:8];

  always_comb begin
    if (quo > Q_MAX) begin
      points = Q_MAX[PTS_W-1:0];
    end else if (quo < Q_MIN) begin
      points = Q_MIN[PTS_W-1:0];
    end else begin
      points = quo[PTS_W-1:0];
    end
  end

endmodule

>>> sv/touch_contact_slot_tracker.sv
// Touch contact slot tracker. One contact event is handled at a time: the lookup
// token walks the chain of slot cells one cell per clock, then the outcome is
// latched, and the commit step writes the slot update and loads the output register.
// A result left waiting at the output holds off the commit of the next event.
// The slot-used bits clear in the reset cycle; there is no clearing pass.
// Depends on tcst_pkg, tcst_cell, tcst_scale and assert_macros.svh.
`include "assert_macros.svh"

module touch_contact_slot_tracker import tcst_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // touch_id[31:0], x_pixel[47:32], y_pixel[63:48]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic        in_tlast,   // batch_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // slot[3:0], x_points[27:4], y_points[51:28], zero pad
  output logic [3:0]  out_tuser,  // status[1:0], event_code[3:2]
  output logic        out_tlast,  // batch_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic signed [PIX_W-1:0] origin_x_r, origin_y_r;
  logic [SCALE_W-1:0]      inv_scale_x_r, inv_scale_y_r;

  cmd_t              cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [PIX_W-1:0]  xpix_r, ypix_r;
  logic              last_r;
  logic              go_r;
  tok_t              done_tok_r;

  tok_t              tok_head;
  tok_t              tok_c [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0] used_vec;
  upd_t              upd;

  logic signed [PTS_W-1:0] xpts, ypts;
  logic              in_acc;
  logic              commit;

  status_t           status;
  logic [IDX_W-1:0]  slot_idx;

  logic              out_tvalid_r;
  logic [55:0]       out_tdata_r;
  logic [3:0]        out_tuser_r;
  logic              out_tlast_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign commit    = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      inv_scale_x_r <= SCALE_W'(65536);
      inv_scale_y_r <= SCALE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:    origin_x_r    <= cfg_data[PIX_W-1:0];
        CFG_ORIGIN_Y:    origin_y_r    <= cfg_data[PIX_W-1:0];
        CFG_INV_SCALE_X: inv_scale_x_r <= cfg_data[SCALE_W-1:0];
        CFG_INV_SCALE_Y: inv_scale_y_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the accepted transaction for the duration of the lookup
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= cmd_t'(in_tuser);
      id_r   <= in_tdata[31:0];
      xpix_r <= in_tdata[47:32];
      ypix_r <= in_tdata[63:48];
      last_r <= in_tlast;
    end
  end

  always_comb begin
    tok_head       = '0;
    tok_head.valid = go_r;
  end

  assign tok_c[0] = tok_head;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
    tcst_cell u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .id       (id_r),
      .tok_in   (tok_c[i]),
      .tok_out  (tok_c[i+1]),
      .upd      (upd),
      .used_o   (used_vec[i])
    );
  end

  tcst_scale u_scale_x (
    .clk       (clk),
    .pixel     (xpix_r),
    .origin    (origin_x_r),
    .inv_scale (inv_scale_x_r),
    .points    (xpts)
  );

  tcst_scale u_scale_y (
    .clk       (clk),
    .pixel     (ypix_r),
    .origin    (origin_y_r),
    .inv_scale (inv_scale_y_r),
    .points    (ypts)
  );

  // resolve the lookup outcome
  always_comb begin
    status       = ST_OK;
    slot_idx     = '0;
    upd.we       = 1'b0;
    upd.set_used = 1'b0;
    upd.idx      = '0;
    upd.id       = id_r;
    if (cmd_r == CMD_BEGIN) begin
      if (done_tok_r.found) begin
        status   = ST_KNOWN;
        slot_idx = done_tok_r.found_idx;
      end else if (done_tok_r.free_found) begin
        slot_idx     = done_tok_r.free_idx;
        upd.we       = commit;
        upd.set_used = 1'b1;
        upd.idx      = done_tok_r.free_idx;
      end else begin
        status = ST_FULL;
      end
    end else begin
      if (done_tok_r.found) begin
        slot_idx = done_tok_r.found_idx;
        upd.we   = commit && (cmd_r != CMD_MOVE);
        upd.idx  = done_tok_r.found_idx;
      end else begin
        status = ST_UNKNOWN;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_c[MAX_SLOTS].valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && tok_c[MAX_SLOTS].valid) begin
      done_tok_r <= tok_c[MAX_SLOTS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_tdata_r[3:0]   <= SLOT_W'(slot_idx);
      out_tdata_r[27:4]  <= (status == ST_OK) ? xpts : '0;
      out_tdata_r[51:28] <= (status == ST_OK) ? ypts : '0;
      out_tdata_r[55:52] <= '0;
      out_tuser_r        <= {cmd_r, status};
      out_tlast_r        <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `TCST_ASSERT(a_one_in_flight, in_acc |=> !in_tready, "transaction accepted while busy")
  `TCST_ASSERT(a_full_means_full, commit && (status == ST_FULL) |-> (&used_vec), "full reported with a free slot")
  `TCST_ASSERT(a_claim_counts, upd.we && upd.set_used |=> $countones(used_vec) == $past($countones(used_vec)) + 1, "slot claim did not add one used slot")
  `TCST_ASSERT(a_free_counts, upd.we && !upd.set_used |=> $countones(used_vec) + 1 == $past($countones(used_vec)), "slot release did not free one slot")
  `TCST_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid && (used_vec == '0), "output or slots live after reset")

endmodule

>>> verif/touch_contact_slot_tracker_checker.sv
// Checker for the touch contact slot tracker: watches the contact, result and
// register channels, keeps its own slot table and compares every result.
// Depends on tcst_pkg.
module touch_contact_slot_tracker_checker import tcst_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // touch_id[31:0], x_pixel[47:32], y_pixel[63:48]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic        in_tlast,   // batch_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // slot[3:0], x_points[27:4], y_points[51:28], zero pad
  input  logic [3:0]  out_tuser,  // status[1:0], event_code[3:2]
  input  logic        out_tlast,  // batch_end
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PTS_MAX = 64'sd8388607;
  localparam longint PTS_MIN = -64'sd8388608;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    cmd_t              event_code;
    logic [PTS_W-1:0]  x_pts;
    logic [PTS_W-1:0]  y_pts;
    logic              batch_end;
  } contact_report_t;

  logic signed [PIX_W-1:0] view_ox;
  logic signed [PIX_W-1:0] view_oy;
  logic [SCALE_W-1:0]      recip_x;
  logic [SCALE_W-1:0]      recip_y;
  logic [MAX_SLOTS-1:0]    slot_busy;
  logic [ID_W-1:0]         slot_id [MAX_SLOTS];
  contact_report_t         reports_due [$];
  int                      mism;

  function automatic logic [PTS_W-1:0] to_design_pts(input logic [PIX_W-1:0] pix,
                                                      input logic signed [PIX_W-1:0] org,
                                                      input logic [SCALE_W-1:0] recip);
    longint offset;
    longint prod;
    longint pts;
    offset = longint'(pix) - longint'(org);
    prod   = offset * longint'(recip);
    pts    = (prod + 128) >>> 8;
    if (pts > PTS_MAX) pts = PTS_MAX;
    if (pts < PTS_MIN) pts = PTS_MIN;
    return pts[PTS_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    contact_report_t exp_r;
    contact_report_t got;
    cmd_t            cmd;
    logic [ID_W-1:0] cid;
    int              hit;
    int              vacant;
    bit              locate;
    if (!rst_n) begin
      view_ox   = '0;
      view_oy   = '0;
      recip_x   = 24'h010000;
      recip_y   = 24'h010000;
      slot_busy = '0;
      reports_due.delete();
      mism = 0;
      pending    <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ORIGIN_X:    view_ox = cfg_data[PIX_W-1:0];
          CFG_ORIGIN_Y:    view_oy = cfg_data[PIX_W-1:0];
          CFG_INV_SCALE_X: recip_x = cfg_data;
          CFG_INV_SCALE_Y: recip_y = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        cmd    = cmd_t'(in_tuser);
        cid    = in_tdata[ID_W-1:0];
        hit    = -1;
        vacant = -1;
        locate = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
          if (slot_busy[i] && slot_id[i] == cid) hit = i;
          if (!slot_busy[i]) vacant = i;
        end
        exp_r            = '0;
        exp_r.status     = ST_OK;
        exp_r.event_code = cmd;
        exp_r.batch_end  = in_tlast;
        if (cmd == CMD_BEGIN) begin
          if (hit >= 0) begin
            exp_r.status = ST_KNOWN;
            exp_r.slot   = hit[SLOT_W-1:0];
          end else if (vacant < 0) begin
            exp_r.status = ST_FULL;
          end else begin
            slot_busy[vacant] = 1'b1;
            slot_id[vacant]   = cid;
            exp_r.slot        = vacant[SLOT_W-1:0];
            locate            = 1'b1;
          end
        end else if (hit < 0) begin
          exp_r.status = ST_UNKNOWN;
        end else begin
          exp_r.slot = hit[SLOT_W-1:0];
          locate     = 1'b1;
          if (cmd != CMD_MOVE) slot_busy[hit] = 1'b0;
        end
        if (locate) begin
          exp_r.x_pts = to_design_pts(in_tdata[47:32], view_ox, recip_x);
          exp_r.y_pts = to_design_pts(in_tdata[63:48], view_oy, recip_y);
        end
        reports_due = {reports_due, exp_r};
      end

      if (out_tvalid && out_tready) begin
        got.status     = status_t'(out_tuser[1:0]);
        got.event_code = cmd_t'(out_tuser[3:2]);
        got.slot       = out_tdata[3:0];
        got.x_pts      = out_tdata[27:4];
        got.y_pts      = out_tdata[51:28];
        got.batch_end  = out_tlast;
        if (reports_due.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display({"%t: result with none expected: status=%0d slot=%0d ev=%0d",
                      " x=%0d y=%0d last=%0b"},
                     $realtime, got.status, got.slot, got.event_code,
                     $signed(got.x_pts), $signed(got.y_pts), got.batch_end);
        end else begin
          exp_r = reports_due.pop_front();
          if (got !== exp_r || out_tdata[55:52] !== 4'h0) begin
            mism++;
            if (mism <= 10)
              $display({"%t: mismatch exp status=%0d slot=%0d ev=%0d x=%0d y=%0d last=%0b",
                        " | got status=%0d slot=%0d ev=%0d x=%0d y=%0d last=%0b pad=%h"},
                       $realtime, exp_r.status, exp_r.slot, exp_r.event_code,
                       $signed(exp_r.x_pts), $signed(exp_r.y_pts), exp_r.batch_end,
                       got.status, got.slot, got.event_code,
                       $signed(got.x_pts), $signed(got.y_pts), got.batch_end,
                       out_tdata[55:52]);
          end
        end
      end

      pending    <= reports_due.size();
      fail_count <= mism;
    end
  end

endmodule

>>> verif/touch_contact_slot_tracker_test.sv
// Testbench top for the touch contact slot tracker: drives contact events and
// register writes, stalls the result side, and gives the verdict.
// Depends on tcst_pkg, the tracker RTL and touch_contact_slot_tracker_checker.
module touch_contact_slot_tracker_test;
  import tcst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_N = 24;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [23:0] cfg_data   = '0;

  int              fail_count;
  int              pending;
  bit              traffic_gaps = 1'b1;
  int              stall_left   = 0;
  logic [ID_W-1:0] id_pool [POOL_N];

  touch_contact_slot_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  touch_contact_slot_tracker_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (traffic_gaps && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_contact(input cmd_t cmd, input logic [ID_W-1:0] id,
                              input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic last);
    if (traffic_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x, id};
    in_tuser  <= cmd;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_contact();
    int              pick;
    cmd_t            cmd;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      id  = $urandom;
      cmd = cmd_t'($urandom_range(1, 3));
    end else begin
      id   = id_pool[$urandom_range(0, POOL_N - 1)];
      pick = $urandom_range(0, 99);
      cmd  = pick < 40 ? CMD_BEGIN : pick < 70 ? CMD_MOVE : pick < 85 ? CMD_END : CMD_CANCEL;
    end
    send_contact(cmd, id, pick_pixel(), pick_pixel(), 1'($urandom_range(0, 1)));
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_view(input logic [PIX_W-1:0] ox, input logic [PIX_W-1:0] oy,
                           input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy);
    put_reg(CFG_ORIGIN_X, {{8{ox[15]}}, ox});
    put_reg(CFG_ORIGIN_Y, {{8{oy[15]}}, oy});
    put_reg(CFG_INV_SCALE_X, sx);
    put_reg(CFG_INV_SCALE_Y, sy);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0]   ox;
    logic [PIX_W-1:0]   oy;
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_contact(CMD_BEGIN,  32'h0000_0000, 16'h0000, 16'h0000, 1'b0);
    send_contact(CMD_BEGIN,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_contact(CMD_BEGIN,  32'h0000_0000, 16'd100,  16'd200,  1'b0);
    send_contact(CMD_MOVE,   32'hFFFF_FFFF, 16'd1234, 16'd4321, 1'b1);
    send_contact(CMD_MOVE,   32'd12345,     16'd10,   16'd20,   1'b0);
    send_contact(CMD_END,    32'hA5A5_A5A5, 16'd30,   16'd40,   1'b1);
    send_contact(CMD_CANCEL, 32'h5A5A_5A5A, 16'd50,   16'd60,   1'b0);
    send_contact(CMD_END,    32'h0000_0000, 16'hFFFF, 16'h0000, 1'b0);
    send_contact(CMD_CANCEL, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 1'b1);
    send_contact(CMD_MOVE,   32'h0000_0000, 16'd5,    16'd6,    1'b0);
    send_contact(CMD_BEGIN,  32'h8000_0000, 16'd7,    16'd9,    1'b0);
    send_contact(CMD_CANCEL, 32'h8000_0000, 16'd11,   16'd13,   1'b1);

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < POOL_N; k++) id_pool[k] = $urandom;

    for (int phase = 1; phase <= 8; phase++) begin
      quiesce();
      case (phase)
        1: begin
          ox = 16'h8000; oy = 16'h7FFF; sx = 24'hFFFFFF; sy = 24'hFFFFFF;
        end
        2: begin
          ox = 16'h7FFF; oy = 16'h8000; sx = 24'd1; sy = 24'd0;
        end
        3: begin
          ox = PIX_W'($urandom); oy = PIX_W'($urandom); sx = 24'h010000; sy = 24'h010000;
        end
        default: begin
          ox = PIX_W'($urandom);
          oy = PIX_W'($urandom);
          sx = SCALE_W'($urandom_range(1, 24'h03FFFF));
          sy = SCALE_W'($urandom_range(1, 24'hFFFFFF));
        end
      endcase
      load_view(ox, oy, sx, sy);
      if (phase == 8) traffic_gaps <= 1'b0;
      repeat (225) random_contact();
    end

    quiesce();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/tcst_pkg.sv
sv/tcst_cell.sv
sv/tcst_scale.sv
sv/touch_contact_slot_tracker.sv
verif/touch_contact_slot_tracker_checker.sv
verif/touch_contact_slot_tracker_test.sv
